/* rtl/segisect_pkg.sv */
// ============================================================================
// Segment intersection package
// Shared widths, the sideband record and the divider step used by the
// segment intersection pipeline.
// ============================================================================
`default_nettype none

package segisect_pkg;

    localparam int CoordW = 32;              // Q16.16 coordinate
    localparam int DiffW  = 33;              // difference of two coordinates
    localparam int WideW  = 66;              // cross products and their differences
    localparam int DenW   = 65;              // normalized denominator and numerator
    localparam int QuoW   = 32;              // quotient bits, |v| < 2**32
    localparam int ProdW  = DenW + QuoW;     // numerator times |v|

    // Fields that ride alongside the divider.
    typedef struct packed {
        logic                      hit;
        logic                      neg_x;
        logic                      neg_y;
        logic signed [CoordW-1:0]  a1x;
        logic signed [CoordW-1:0]  a1y;
    } side_t;

    // One lane of the restoring divider.
    typedef struct packed {
        logic [DenW-1:0] rem;
        logic [QuoW-1:0] low;
        logic [QuoW-1:0] quo;
    } div_lane_t;

    // One restoring step: bring in the next dividend bit and try a subtract.
    function automatic div_lane_t div_step(div_lane_t cur, logic [DenW-1:0] den);
        logic [DenW:0] trial;
        logic [DenW:0] diff;
        div_lane_t     nxt;
        trial    = {cur.rem, cur.low[QuoW-1]};
        diff     = trial - {1'b0, den};
        nxt.low  = {cur.low[QuoW-2:0], 1'b0};
        if (trial >= {1'b0, den})
        begin
            nxt.rem = diff[DenW-1:0];
            nxt.quo = {cur.quo[QuoW-2:0], 1'b1};
        end
        else
        begin
            nxt.rem = trial[DenW-1:0];
            nxt.quo = {cur.quo[QuoW-2:0], 1'b0};
        end
        return nxt;
    endfunction

endpackage

`default_nettype wire

/* rtl/segment_intersection_2d_unit.sv */
// ============================================================================
// Segment intersection unit
// Tests two Q16.16 segments for intersection and gives the rounded,
// saturated crossing point.
// ============================================================================
// Throughput is one item per cycle; the whole pipeline advances as one, so a
// stalled result holds every stage, and the 32-step divider sets the depth.
// Reset clears every valid bit at once; the datapath registers are not reset.
// The block keeps no state between items, and each item gives one result.
`default_nettype none

module segment_intersection_2d_unit (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic signed [31:0]        a1x,
    input  wire logic signed [31:0]        a1y,
    input  wire logic signed [31:0]        a2x,
    input  wire logic signed [31:0]        a2y,
    input  wire logic signed [31:0]        b1x,
    input  wire logic signed [31:0]        b1y,
    input  wire logic signed [31:0]        b2x,
    input  wire logic signed [31:0]        b2y,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic                           hit,
    output logic signed [31:0]             cross_x,
    output logic signed [31:0]             cross_y
);

    localparam int CW = segisect_pkg::CoordW;
    localparam int DW = segisect_pkg::DiffW;
    localparam int WW = segisect_pkg::WideW;
    localparam int NW = segisect_pkg::DenW;
    localparam int QW = segisect_pkg::QuoW;
    localparam int PW = segisect_pkg::ProdW;
    localparam int LoW = 33;                 // low slice of the numerator
    localparam int SW  = QW + 3;             // width of the final signed sum

    // The whole pipeline moves when the output register is free or taken.
    logic adv;
    assign adv      = !out_valid || !out_stall;
    assign in_stall = !adv;

    // Stage 1: direction vectors and the offset between start points.
    logic                  s1_valid_reg;
    logic signed [DW-1:0]  v1x_reg, v1y_reg, v2x_reg, v2y_reg, dx_reg, dy_reg;
    logic signed [CW-1:0]  s1_a1x_reg, s1_a1y_reg;

    // Stage 2: the six cross products.
    logic                  s2_valid_reg;
    logic signed [WW-1:0]  den_a_reg, den_b_reg, sn_a_reg, sn_b_reg, tn_a_reg, tn_b_reg;
    logic signed [DW-1:0]  s2_v1x_reg, s2_v1y_reg;
    logic signed [CW-1:0]  s2_a1x_reg, s2_a1y_reg;

    // Stage 3: denominator and the two numerators.
    logic                  s3_valid_reg;
    logic signed [WW-1:0]  den_reg, sn_reg, tn_reg;
    logic signed [DW-1:0]  s3_v1x_reg, s3_v1y_reg;
    logic signed [CW-1:0]  s3_a1x_reg, s3_a1y_reg;

    // Stage 4: signs folded so the denominator is not negative; |v1| split off.
    logic                  s4_valid_reg;
    logic signed [WW-1:0]  den_n_reg, sn_n_reg, tn_n_reg;
    logic [QW-1:0]         mvx_reg, mvy_reg;
    logic                  s4_neg_x_reg, s4_neg_y_reg;
    logic signed [CW-1:0]  s4_a1x_reg, s4_a1y_reg;

    // Stage 5: the hit decision.
    logic                  s5_valid_reg;
    logic [NW-1:0]         s5_den_reg, s5_tn_reg;
    logic [QW-1:0]         s5_mvx_reg, s5_mvy_reg;
    segisect_pkg::side_t   s5_side_reg;

    // Stage 6: partial products of t's numerator and |v1|.
    logic                  s6_valid_reg;
    logic [LoW+QW-1:0]     pl_x_reg, pl_y_reg;
    logic [NW-LoW+QW-1:0]  ph_x_reg, ph_y_reg;
    logic [NW-1:0]         s6_den_reg;
    segisect_pkg::side_t   s6_side_reg;

    // Stage 7: full dividends.
    logic                  s7_valid_reg;
    logic [PW-1:0]         prod_x_reg, prod_y_reg;
    logic [NW-1:0]         s7_den_reg;
    segisect_pkg::side_t   s7_side_reg;

    // Divider outputs.
    logic                     dv_valid;
    logic [NW-1:0]            dv_den;
    segisect_pkg::div_lane_t  dv_lane_x, dv_lane_y;
    segisect_pkg::side_t      dv_side;

    // Rounding stage.
    logic                  rd_valid_reg;
    logic [QW:0]           q_x_reg, q_y_reg;
    segisect_pkg::side_t   rd_side_reg;

    // Stage-local combinational values.
    logic signed [DW-1:0]  mv_x_full, mv_y_full;
    logic [QW:0]           q_x_next, q_y_next;
    logic signed [SW-1:0]  off_x, off_y, sum_x, sum_y;
    logic signed [CW-1:0]  cross_x_next, cross_y_next;
    logic                  hit_next;

    always_comb
    begin
        mv_x_full = s3_v1x_reg[DW-1] ? -s3_v1x_reg : s3_v1x_reg;
        mv_y_full = s3_v1y_reg[DW-1] ? -s3_v1y_reg : s3_v1y_reg;

        hit_next  = (den_n_reg != '0) && !sn_n_reg[WW-1] && !tn_n_reg[WW-1]
                    && (sn_n_reg <= den_n_reg) && (tn_n_reg <= den_n_reg);

        // Round half away from zero on the magnitude.
        q_x_next  = {1'b0, dv_lane_x.quo}
                    + {{QW{1'b0}}, ({dv_lane_x.rem, 1'b0} >= {1'b0, dv_den})};
        q_y_next  = {1'b0, dv_lane_y.quo}
                    + {{QW{1'b0}}, ({dv_lane_y.rem, 1'b0} >= {1'b0, dv_den})};

        off_x     = rd_side_reg.neg_x ? -$signed({2'b00, q_x_reg}) : $signed({2'b00, q_x_reg});
        off_y     = rd_side_reg.neg_y ? -$signed({2'b00, q_y_reg}) : $signed({2'b00, q_y_reg});
        sum_x     = $signed({{(SW-CW){rd_side_reg.a1x[CW-1]}}, rd_side_reg.a1x}) + off_x;
        sum_y     = $signed({{(SW-CW){rd_side_reg.a1y[CW-1]}}, rd_side_reg.a1y}) + off_y;

        // Saturate to the Q16.16 range whenever the top bits disagree.
        if (sum_x[SW-1:CW-1] == '0 || sum_x[SW-1:CW-1] == '1)
        begin
            cross_x_next = sum_x[CW-1:0];
        end
        else
        begin
            cross_x_next = sum_x[SW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        end
        if (sum_y[SW-1:CW-1] == '0 || sum_y[SW-1:CW-1] == '1)
        begin
            cross_y_next = sum_y[CW-1:0];
        end
        else
        begin
            cross_y_next = sum_y[SW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        end
        if (!rd_side_reg.hit)
        begin
            cross_x_next = '0;
            cross_y_next = '0;
        end
    end

    // Valid bits travel with the items and are the only reset state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
            rd_valid_reg <= 1'b0;
            out_valid    <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
            s7_valid_reg <= s6_valid_reg;
            rd_valid_reg <= dv_valid;
            out_valid    <= rd_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // Stage 1
            v1x_reg    <= $signed({a2x[CW-1], a2x}) - $signed({a1x[CW-1], a1x});
            v1y_reg    <= $signed({a2y[CW-1], a2y}) - $signed({a1y[CW-1], a1y});
            v2x_reg    <= $signed({b2x[CW-1], b2x}) - $signed({b1x[CW-1], b1x});
            v2y_reg    <= $signed({b2y[CW-1], b2y}) - $signed({b1y[CW-1], b1y});
            dx_reg     <= $signed({a1x[CW-1], a1x}) - $signed({b1x[CW-1], b1x});
            dy_reg     <= $signed({a1y[CW-1], a1y}) - $signed({b1y[CW-1], b1y});
            s1_a1x_reg <= a1x;
            s1_a1y_reg <= a1y;

            // Stage 2
            den_a_reg  <= v1x_reg * v2y_reg;
            den_b_reg  <= v2x_reg * v1y_reg;
            sn_a_reg   <= v1x_reg * dy_reg;
            sn_b_reg   <= v1y_reg * dx_reg;
            tn_a_reg   <= v2x_reg * dy_reg;
            tn_b_reg   <= v2y_reg * dx_reg;
            s2_v1x_reg <= v1x_reg;
            s2_v1y_reg <= v1y_reg;
            s2_a1x_reg <= s1_a1x_reg;
            s2_a1y_reg <= s1_a1y_reg;

            // Stage 3: the true values stay well inside the word.
            den_reg    <= den_a_reg - den_b_reg;
            sn_reg     <= sn_a_reg - sn_b_reg;
            tn_reg     <= tn_a_reg - tn_b_reg;
            s3_v1x_reg <= s2_v1x_reg;
            s3_v1y_reg <= s2_v1y_reg;
            s3_a1x_reg <= s2_a1x_reg;
            s3_a1y_reg <= s2_a1y_reg;

            // Stage 4
            den_n_reg    <= den_reg[WW-1] ? -den_reg : den_reg;
            sn_n_reg     <= den_reg[WW-1] ? -sn_reg  : sn_reg;
            tn_n_reg     <= den_reg[WW-1] ? -tn_reg  : tn_reg;
            mvx_reg      <= mv_x_full[QW-1:0];
            mvy_reg      <= mv_y_full[QW-1:0];
            s4_neg_x_reg <= s3_v1x_reg[DW-1];
            s4_neg_y_reg <= s3_v1y_reg[DW-1];
            s4_a1x_reg   <= s3_a1x_reg;
            s4_a1y_reg   <= s3_a1y_reg;

            // Stage 5
            s5_den_reg        <= den_n_reg[NW-1:0];
            s5_tn_reg         <= tn_n_reg[NW-1:0];
            s5_mvx_reg        <= mvx_reg;
            s5_mvy_reg        <= mvy_reg;
            s5_side_reg.hit   <= hit_next;
            s5_side_reg.neg_x <= s4_neg_x_reg;
            s5_side_reg.neg_y <= s4_neg_y_reg;
            s5_side_reg.a1x   <= s4_a1x_reg;
            s5_side_reg.a1y   <= s4_a1y_reg;

            // Stage 6
            pl_x_reg    <= s5_tn_reg[LoW-1:0] * s5_mvx_reg;
            pl_y_reg    <= s5_tn_reg[LoW-1:0] * s5_mvy_reg;
            ph_x_reg    <= s5_tn_reg[NW-1:LoW] * s5_mvx_reg;
            ph_y_reg    <= s5_tn_reg[NW-1:LoW] * s5_mvy_reg;
            s6_den_reg  <= s5_den_reg;
            s6_side_reg <= s5_side_reg;

            // Stage 7
            prod_x_reg  <= {{(PW-LoW-QW){1'b0}}, pl_x_reg} + {ph_x_reg, {LoW{1'b0}}};
            prod_y_reg  <= {{(PW-LoW-QW){1'b0}}, pl_y_reg} + {ph_y_reg, {LoW{1'b0}}};
            s7_den_reg  <= s6_den_reg;
            s7_side_reg <= s6_side_reg;

            // Rounding
            q_x_reg     <= q_x_next;
            q_y_reg     <= q_y_next;
            rd_side_reg <= dv_side;

            // Output register
            hit         <= rd_side_reg.hit;
            cross_x     <= cross_x_next;
            cross_y     <= cross_y_next;
        end
    end

    segisect_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_valid   (s7_valid_reg),
        .in_den     (s7_den_reg),
        .in_prod_x  (prod_x_reg),
        .in_prod_y  (prod_y_reg),
        .in_side    (s7_side_reg),
        .out_valid  (dv_valid),
        .out_den    (dv_den),
        .out_lane_x (dv_lane_x),
        .out_lane_y (dv_lane_y),
        .out_side   (dv_side)
    );

`ifndef SYNTHESIS
    // A miss always reports the origin.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !hit) |-> (cross_x == '0 && cross_y == '0))
        else $error("miss with nonzero point");

    // Input back-pressure comes only from a held result.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a held result");

    // An item in the rounding stage reaches the output on the next move.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rd_valid_reg && adv) |=> out_valid)
        else $error("item lost after rounding");

    // A hit needs a nonzero denominator all the way through the divider.
    assert property (@(posedge clk) disable iff (!rst_n)
        (dv_valid && dv_side.hit) |-> (dv_den != '0))
        else $error("hit with zero denominator");
`endif

endmodule

`default_nettype wire

/* rtl/segisect_div.sv */
// ============================================================================
// Segment intersection divider
// Pipelined restoring divider, one quotient bit per stage, with an x lane
// and a y lane sharing one denominator.
// ============================================================================
`default_nettype none

module segisect_div (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 adv,
    input  wire logic                                 in_valid,
    input  wire logic [segisect_pkg::DenW-1:0]        in_den,
    input  wire logic [segisect_pkg::ProdW-1:0]       in_prod_x,
    input  wire logic [segisect_pkg::ProdW-1:0]       in_prod_y,
    input  wire segisect_pkg::side_t                  in_side,
    output logic                                      out_valid,
    output logic [segisect_pkg::DenW-1:0]             out_den,
    output segisect_pkg::div_lane_t                   out_lane_x,
    output segisect_pkg::div_lane_t                   out_lane_y,
    output segisect_pkg::side_t                       out_side
);

    localparam int Steps = segisect_pkg::QuoW;

    logic                            valid_reg [Steps];
    logic [segisect_pkg::DenW-1:0]   den_reg   [Steps];
    segisect_pkg::div_lane_t         lane_x_reg[Steps];
    segisect_pkg::div_lane_t         lane_y_reg[Steps];
    segisect_pkg::side_t             side_reg  [Steps];

    segisect_pkg::div_lane_t         start_x;
    segisect_pkg::div_lane_t         start_y;

    // The top part of the dividend is already below the denominator on a hit,
    // so only the low quotient bits need a step each.
    always_comb
    begin
        start_x.rem = in_prod_x[segisect_pkg::ProdW-1:segisect_pkg::QuoW];
        start_x.low = in_prod_x[segisect_pkg::QuoW-1:0];
        start_x.quo = '0;
        start_y.rem = in_prod_y[segisect_pkg::ProdW-1:segisect_pkg::QuoW];
        start_y.low = in_prod_y[segisect_pkg::QuoW-1:0];
        start_y.quo = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < Steps; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            valid_reg[0] <= in_valid;
            for (int k = 1; k < Steps; k++)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            den_reg[0]    <= in_den;
            side_reg[0]   <= in_side;
            lane_x_reg[0] <= segisect_pkg::div_step(start_x, in_den);
            lane_y_reg[0] <= segisect_pkg::div_step(start_y, in_den);
            for (int k = 1; k < Steps; k++)
            begin
                den_reg[k]    <= den_reg[k-1];
                side_reg[k]   <= side_reg[k-1];
                lane_x_reg[k] <= segisect_pkg::div_step(lane_x_reg[k-1], den_reg[k-1]);
                lane_y_reg[k] <= segisect_pkg::div_step(lane_y_reg[k-1], den_reg[k-1]);
            end
        end
    end

    assign out_valid  = valid_reg[Steps-1];
    assign out_den    = den_reg[Steps-1];
    assign out_lane_x = lane_x_reg[Steps-1];
    assign out_lane_y = lane_y_reg[Steps-1];
    assign out_side   = side_reg[Steps-1];

endmodule

`default_nettype wire
